### design/mf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, sizes and helpers of the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int ROW_W      = 11;
  localparam int PIX_W      = 8;
  localparam int MIN_DIM    = 3;
  localparam int WIDTH_RST  = 720;
  localparam int HEIGHT_RST = 480;
  localparam int WIN_N      = 9;
  localparam int WIN_CENTER = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // per-item control carried alongside the pixel
  typedef struct packed {
    logic emit;
    logic border;
    logic eof;
  } ctrl_t;

  typedef struct packed {
    logic   eof;
    pixel_t pixel;
  } res_t;

  // saturating row increment
  function automatic row_t row_inc(input row_t r);
    return (r == '1) ? r : row_t'(r + row_t'(1));
  endfunction

endpackage

### design/mf3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mf3_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median
// Median of nine pixels by a 19 compare-exchange selection network.
// ----------------------------------------------------------------------------
module mf3_median import mf3_pkg::*; (
  input  pixel_t win_i [WIN_N],
  output pixel_t med_o
);

  pixel_t p [WIN_N];

  // returns {min, max}
  function automatic logic [2*PIX_W-1:0] sort2(input pixel_t a, input pixel_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      p[i] = win_i[i];
    end
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[1]} = sort2(p[0], p[1]);
    {p[3], p[4]} = sort2(p[3], p[4]);
    {p[6], p[7]} = sort2(p[6], p[7]);
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[3]} = sort2(p[0], p[3]);
    {p[5], p[8]} = sort2(p[5], p[8]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[3], p[6]} = sort2(p[3], p[6]);
    {p[1], p[4]} = sort2(p[1], p[4]);
    {p[2], p[5]} = sort2(p[2], p[5]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    {p[6], p[4]} = sort2(p[6], p[4]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    med_o = p[WIN_CENTER];
  end

endmodule

### design/median_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for raster-order 8-bit greyscale frames.
// Pipeline: the beat causing a result passes the line store read, the window
//   shift and the median into the output queue, whose write raises out_valid.
// Throughput: one beat per cycle while in_ready allows it (the output queue
//   has room), set by the single-pass median network and one read plus one
//   write per line store RAM each cycle.
// Reset (rst_n low, synchronous): counters, window, pipeline and output queue
//   clear, width/height return to 720/480; line stores are not cleared.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel_in,
  input  logic              in_is_padding,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pixel_out,
  output logic              out_end_of_frame,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  dim_t cfg_w_r, cfg_h_r;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  // position counters
  col_t in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  row_t in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  // accept-cycle decode
  dim_t  fw, fh, w_m1, h_m1, ic_inc, oc_inc;
  col_t  ic0, oc0;
  row_t  ir0, or0;
  ctrl_t ctrl_a;
  logic  acc;

  // stage 1: line store data is returning
  logic   s1_v_r, s1_fwd_r;
  ctrl_t  s1_ctrl_r;
  pixel_t s1_px_r, fwd_up_r, fwd_lo_r;
  col_t   s1_col_r;
  pixel_t up_rd, lo_rd, up_cur, lo_cur;

  // stage 2: window holds the item's neighborhood
  logic   s2_v_r, s2_border_r, s2_eof_r;
  pixel_t win_r [WIN_N];
  pixel_t med;

  // output queue
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, occ;
  logic               push, pop;

  // ---------------------------------------------------------------------------
  // configuration port, low address bits ignored
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= dim_t'(WIDTH_RST);
      cfg_h_r <= dim_t'(HEIGHT_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  cfg_w_r <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_h_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_w_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_h_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // flow control: admit a beat only if the queue can absorb every beat in flight
  // ---------------------------------------------------------------------------
  assign occ      = CNT_W'(s1_v_r) + CNT_W'(s2_v_r) + cnt_r;
  assign in_ready = occ < CNT_W'(FIFO_DEPTH);
  assign acc      = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // position tracking, decided when the beat is accepted
  // ---------------------------------------------------------------------------
  always_comb begin
    // clamp sizes to the legal range
    if (cfg_w_r < dim_t'(MIN_DIM))        fw = dim_t'(MIN_DIM);
    else if (cfg_w_r > dim_t'(MAX_WIDTH)) fw = dim_t'(MAX_WIDTH);
    else                                  fw = cfg_w_r;
    if (cfg_h_r < dim_t'(MIN_DIM))         fh = dim_t'(MIN_DIM);
    else if (cfg_h_r > dim_t'(MAX_HEIGHT)) fh = dim_t'(MAX_HEIGHT);
    else                                   fh = cfg_h_r;
    w_m1 = fw - dim_t'(1);
    h_m1 = fh - dim_t'(1);

    // wrap counters left beyond a size that shrank
    if (dim_t'(in_col_r) >= fw) begin
      ic0 = '0;
      ir0 = row_inc(in_row_r);
    end else begin
      ic0 = in_col_r;
      ir0 = in_row_r;
    end
    if (dim_t'(out_col_r) >= fw) begin
      oc0 = '0;
      or0 = row_inc(out_row_r);
    end else begin
      oc0 = out_col_r;
      or0 = out_row_r;
    end

    ctrl_a.emit   = (ir0 >= row_t'(2)) || ((ir0 == row_t'(1)) && (ic0 != '0));
    ctrl_a.eof    = (or0 >= row_t'(h_m1)) && (dim_t'(oc0) >= w_m1);
    ctrl_a.border = (or0 == '0) || (or0 >= row_t'(h_m1)) ||
                    (oc0 == '0) || (dim_t'(oc0) >= w_m1);

    ic_inc = dim_t'(ic0) + dim_t'(1);
    oc_inc = dim_t'(oc0) + dim_t'(1);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc) begin
      if (ic_inc >= fw) begin
        in_col_nxt = '0;
        in_row_nxt = row_inc(ir0);
      end else begin
        in_col_nxt = ic_inc[COL_W-1:0];
        in_row_nxt = ir0;
      end
      out_col_nxt = oc0;
      out_row_nxt = or0;
      if (ctrl_a.emit) begin
        if (ctrl_a.eof) begin
          // frame done: next beat opens a new frame
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (oc_inc >= fw) begin
          out_col_nxt = '0;
          out_row_nxt = row_inc(or0);
        end else begin
          out_col_nxt = oc_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: read at accept, written back in the next cycle, not later
  // ---------------------------------------------------------------------------
  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (lo_cur),
    .raddr (ic0),
    .rdata (up_rd)
  );

  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .raddr (ic0),
    .rdata (lo_rd)
  );

  // a read that collides with the write landing at the same edge returns old
  // data, so the written values are forwarded instead
  assign up_cur = s1_fwd_r ? fwd_up_r : up_rd;
  assign lo_cur = s1_fwd_r ? fwd_lo_r : lo_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_fwd_r  <= s1_v_r && (s1_col_r == ic0);
    fwd_up_r  <= lo_cur;
    fwd_lo_r  <= s1_px_r;
    s1_ctrl_r <= ctrl_a;
    s1_col_r  <= ic0;
    // padding counts as a black pixel
    s1_px_r   <= in_is_padding ? '0 : in_pixel_in;
  end

  // ---------------------------------------------------------------------------
  // window shift, newest column on the right
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s2_v_r <= s1_v_r && s1_ctrl_r.emit;
      if (s1_v_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]     <= win_r[r*3 + 1];
          win_r[r*3 + 1] <= win_r[r*3 + 2];
        end
        win_r[2] <= up_cur;
        win_r[5] <= lo_cur;
        win_r[8] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_border_r <= s1_ctrl_r.border;
    s2_eof_r    <= s1_ctrl_r.eof;
  end

  mf3_median u_median (
    .win_i (win_r),
    .med_o (med)
  );

  // ---------------------------------------------------------------------------
  // output queue, decouples out_ready from the pipeline
  // ---------------------------------------------------------------------------
  assign push = s2_v_r;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      // border pixels pass the original center through
      fifo_r[wr_ptr_r].eof   <= s2_eof_r;
      fifo_r[wr_ptr_r].pixel <= s2_border_r ? win_r[WIN_CENTER] : med;
    end
  end

  assign out_valid        = cnt_r != '0;
  assign out_pixel_out    = fifo_r[rd_ptr_r].pixel;
  assign out_end_of_frame = fifo_r[rd_ptr_r].eof;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= CNT_W'(FIFO_DEPTH))
    else $error("beats in flight exceed output queue depth");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CNT_W'(FIFO_DEPTH)) || pop)
    else $error("push into a full output queue");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ctrl_a.emit && ctrl_a.eof) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not cleared after end of frame");

  a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ctrl_a.emit) |=> ##1 s2_v_r)
    else $error("emitting beat lost between stages");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 3x3 median filter. Frames of random
// size and content go in over a valid/ready stream, with padding beats to
// flush each frame; a scoreboard class rebuilds the line stores and window,
// predicts every result pixel and its end-of-frame flag, and compares them
// beat by beat with what the filter sends out under random back-pressure.
// ----------------------------------------------------------------------------
module tb import mf3_pkg::*;;

  class median_scoreboard;
    dim_t        width_reg;
    dim_t        height_reg;
    pixel_t      upper_line [MAX_WIDTH];
    pixel_t      lower_line [MAX_WIDTH];
    pixel_t      window [WIN_N];
    int unsigned in_col, in_row, out_col, out_row;
    res_t        expected_pixels [$];
    int          errors;
    int          n_checked;

    function new();
      width_reg  = dim_t'(WIDTH_RST);
      height_reg = dim_t'(HEIGHT_RST);
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      in_col    = 0;
      in_row    = 0;
      out_col   = 0;
      out_row   = 0;
      errors    = 0;
      n_checked = 0;
    endfunction

    function int unsigned clamp_dim(dim_t v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned rows();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    function void write_reg(reg_idx_t idx, dim_t val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function bit at_frame_start();
      return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    function int outstanding();
      return expected_pixels.size();
    endfunction

    // one accepted input beat: shift the window, update line stores, maybe
    // queue one expected result pixel
    function void take_beat(pixel_t pix, logic pad);
      int unsigned w, h;
      pixel_t      px;
      pixel_t      nbr [$];
      bit          emit, on_border;
      res_t        r;
      w  = cols();
      h  = rows();
      px = pad ? '0 : pix;
      if (in_col >= w) begin
        in_col = 0;
        if (in_row < 'h7FF) in_row++;
      end
      if (out_col >= w) begin
        out_col = 0;
        if (out_row < 'h7FF) out_row++;
      end
      for (int k = 0; k < 3; k++) begin
        window[3*k]   = window[3*k+1];
        window[3*k+1] = window[3*k+2];
      end
      window[2] = upper_line[in_col];
      window[5] = lower_line[in_col];
      window[8] = px;
      upper_line[in_col] = lower_line[in_col];
      lower_line[in_col] = px;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        if (in_row < 'h7FF) in_row++;
      end
      if (!emit) return;
      on_border = (out_row == 0) || (out_row >= h - 1) ||
                  (out_col == 0) || (out_col >= w - 1);
      foreach (window[k]) nbr.push_back(window[k]);
      nbr.sort();
      r.pixel = on_border ? window[WIN_CENTER] : nbr[WIN_CENTER];
      r.eof   = (out_row >= h - 1) && (out_col >= w - 1);
      expected_pixels.push_back(r);
      if (r.eof) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          if (out_row < 'h7FF) out_row++;
        end
      end
    endfunction

    function void check_beat(pixel_t pix, logic eof);
      res_t e;
      n_checked++;
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("unexpected result beat: pixel_out %0d end_of_frame %0b", pix, eof);
        return;
      end
      e = expected_pixels.pop_front();
      if (pix !== e.pixel) begin
        errors++;
        $error("pixel_out: expected %0d, actual %0d", e.pixel, pix);
      end
      if (eof !== e.eof) begin
        errors++;
        $error("end_of_frame: expected %0b, actual %0b", e.eof, eof);
      end
    endfunction
  endclass

  localparam int LONG_HOLD      = 300;   // one long receiver stall
  localparam int HOLD_AT_RESULT = 30;    // lands inside the wide frame's results
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int WIDE_BEATS     = 1065;  // one full 1024 row, one more beat, then 40 results
  localparam int RANDOM_BEATS   = 300;
  localparam int CALM_AFTER     = 220;   // no idling from here on
  localparam int DRAIN_CYCLES   = 8;     // pipeline is 3 deep
  localparam int TAIL_CYCLES    = 20;
  localparam int N_DIRECTED     = 26;

  typedef enum int {
    FRAME_CLEAN,        // exact pixel count, exact flush
    FRAME_SHORT_FLUSH,  // flush cut short, resync noise finishes it
    FRAME_LONG_FLUSH,   // extra flush beats spill into the next frame
    FRAME_NOISY,        // padding flags at random through the frame
    FRAME_PIXEL_FLUSH   // real pixels where flush beats are due
  } frame_kind_t;

  // two 3x3 frames with 4 flush beats each
  // first: value extremes; second: padding inside the frame and a pixel
  // sent where padding is due
  localparam pixel_t DIR_PIX [N_DIRECTED] = '{
    8'd0,   8'd255, 8'd0,   8'd255, 8'd128, 8'd255, 8'd1,   8'd254, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255,
    8'd200, 8'd17,  8'd255, 8'd3,   8'd255, 8'd90,  8'd255, 8'd0,   8'd128,
    8'd0,   8'd77,  8'd255, 8'd12
  };
  localparam bit DIR_PAD [N_DIRECTED] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b1
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              in_is_padding;
  logic              out_valid;
  logic              out_ready;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              out_end_of_frame;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  median_scoreboard sb = new();

  bit          calm        = 1'b0;  // last stretch: no idling at all
  bit          sender_gaps = 1'b1;
  int unsigned beats_sent  = 0;

  median_filter_3x3 DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_in      (in_pixel_in),
    .in_is_padding    (in_is_padding),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_frame (out_end_of_frame),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one input beat, hold it until accepted, then feed the predictor
  task automatic send_beat(input pixel_t pix, input logic pad);
    if (sender_gaps && !calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_in   <= pix;
    in_is_padding <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_beat(pix, pad);
    beats_sent++;
    @(negedge clk);
  endtask

  // setup cycle, access cycle, then the bus is parked idle
  task automatic apb_write(input reg_idx_t idx, input dim_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // only touch the size registers once the filter has gone quiet
  task automatic write_sizes(input dim_t w, input dim_t h);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
  endtask

  // keep feeding padding-heavy noise until the filter closes its frame
  task automatic resync();
    while (!sb.at_frame_start())
      send_beat(pixel_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input frame_kind_t kind);
    int unsigned w, h, n_flush;
    logic        pad;
    w       = sb.cols();
    h       = sb.rows();
    n_flush = w + 1;
    if (kind == FRAME_SHORT_FLUSH) n_flush = $urandom_range(0, w);
    else if (kind == FRAME_LONG_FLUSH) n_flush = w + 1 + $urandom_range(1, 3);
    sender_gaps = ($urandom_range(0, 3) != 0);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (kind == FRAME_NOISY) pad = 1'($urandom_range(0, 1));
      else pad = ($urandom_range(0, 31) == 0);
      send_beat(pixel_t'($urandom_range(0, 255)), pad);
    end
    for (int unsigned i = 0; i < n_flush; i++) begin
      if (kind == FRAME_PIXEL_FLUSH) pad = 1'($urandom_range(0, 1));
      else pad = 1'b1;
      send_beat(pixel_t'($urandom_range(0, 255)), pad);
    end
    resync();
  endtask

  // main stimulus
  initial begin : stimulus
    int unsigned start_beats;
    int unsigned pick;
    frame_kind_t kind;
    in_valid      = 1'b0;
    in_pixel_in   = '0;
    in_is_padding = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_n         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: sizes below the minimum clamp to 3x3
    write_sizes(dim_t'(0), dim_t'(1));
    foreach (DIR_PIX[i]) send_beat(DIR_PIX[i], DIR_PAD[i]);

    // widest frame, all register bits set: the row wraps at 1024 columns,
    // so results only show up if the width clamps; cut short by a shrink
    write_sizes(dim_t'(2047), dim_t'(0));
    repeat (WIDE_BEATS) send_beat(pixel_t'($urandom_range(0, 255)), 1'b0);
    write_sizes(dim_t'(5), dim_t'(4));
    resync();

    // shrink the frame while one is half done: counters past the new size
    // wrap and the result row is already past the last row
    write_sizes(dim_t'(10), dim_t'(8));
    repeat (45) send_beat(pixel_t'($urandom_range(0, 255)), 1'b0);
    write_sizes(dim_t'(4), dim_t'(3));
    resync();

    // random frames, mostly well formed
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      if (beats_sent - start_beats >= CALM_AFTER) calm = 1'b1;
      if ($urandom_range(0, 1) == 1)
        write_sizes(dim_t'($urandom_range(0, 14)), dim_t'($urandom_range(0, 10)));
      pick = $urandom_range(0, 9);
      case (pick)
        6: kind = FRAME_SHORT_FLUSH;
        7: kind = FRAME_LONG_FLUSH;
        8: kind = FRAME_NOISY;
        9: kind = FRAME_PIXEL_FLUSH;
        default: kind = FRAME_CLEAN;
      endcase
      send_frame(kind);
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // result side back-pressure: random bursts, quiet stretches, and one
  // long hold so the filter backs up into its input
  initial begin : result_sink
    bit held_long;
    bit sink_gaps;
    held_long = 1'b0;
    sink_gaps = 1'b1;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_long && sb.n_checked >= HOLD_AT_RESULT) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (sink_gaps && !calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 255) == 0) sink_gaps = !sink_gaps;
      end
    end
  end

  // check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_pixel_out, out_end_of_frame);
  end

  // watchdog: too long with no beat moving on any port
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

endmodule

### median_filter_3x3.f
design/mf3_pkg.sv
design/mf3_ram.sv
design/mf3_median.sv
design/median_filter_3x3.sv
dv/tb.sv
